/* rtl/eol_normalizing_line_splitter_assert.svh */
// Assertion macros shared by the line splitter modules.
// Each macro takes a label, the clock, the reset, a condition and a consequence.
`ifndef EOL_NORMALIZING_LINE_SPLITTER_ASSERT_SVH
`define EOL_NORMALIZING_LINE_SPLITTER_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define ELNS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line splitter check failed");

// The consequence must hold in the cycle after the condition.
`define ELNS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line splitter check failed");

`endif

/* rtl/elns_pkg.sv */
// ----------------------------------------------------------------------------
// elns_pkg
// Constants, codes and shared types of the end-of-line normalizing splitter.
// ----------------------------------------------------------------------------
package elns_pkg;

   localparam int LINE_COUNT_BITS = 32;
   localparam logic [LINE_COUNT_BITS-1:0] LINE_COUNT_ONE = 1;

   localparam logic [7:0] CH_FF      = 8'd12;
   localparam logic [7:0] CH_LF      = 8'd10;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_NUL     = 8'd0;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] FOLD_OFFSET = 8'h20;

   // End-of-line modes; codes above MODE_ANY behave as MODE_ANY.
   localparam logic [2:0] MODE_CR   = 3'd0;
   localparam logic [2:0] MODE_LF   = 3'd1;
   localparam logic [2:0] MODE_CRLF = 3'd2;
   localparam logic [2:0] MODE_LFCR = 3'd3;
   localparam logic [2:0] MODE_ANY  = 3'd4;

   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_CR   = 2'd1;
   localparam logic [1:0] PEND_LF   = 2'd2;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EOL_MODE  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FOLD_CASE = 4'd1;

   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = 2;
   localparam int QUEUE_COUNT_BITS = 3;
   localparam logic [QUEUE_COUNT_BITS-1:0] QUEUE_FULL = QUEUE_COUNT_BITS'(QUEUE_DEPTH);

   localparam int MAX_RESULTS = 3;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [7:0]  folded_byte;
      logic        has_byte;
      logic        end_of_line;
      logic        line_complete;
      logic [31:0] line_number;
   } result_type;

   // All results caused by one request, slot 0 first.
   typedef struct packed {
      logic [1:0]                   count;
      result_type [MAX_RESULTS-1:0] slot;
   } bundle_type;

   // Handshake between the front end and the queue.
   typedef struct packed {
      logic push;
      logic full;
   } queue_ctl_type;

endpackage

/* rtl/elns_if.sv */
// ----------------------------------------------------------------------------
// elns channel interfaces
// Request, response and register-write channels of the line splitter.
// ----------------------------------------------------------------------------
interface elns_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, in_byte, end_of_input, input ready);
   modport sink (input valid, in_byte, end_of_input, output ready);
endinterface

interface elns_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [7:0]  folded_byte;
   logic        has_byte;
   logic        end_of_line;
   logic        line_complete;
   logic [31:0] line_number;

   modport source (output valid, out_byte, folded_byte, has_byte, end_of_line,
                   line_complete, line_number, input ready);
   modport sink (input valid, out_byte, folded_byte, has_byte, end_of_line,
                 line_complete, line_number, output ready);
endinterface

interface elns_csr_if;
   logic                                valid;
   logic                                ready;
   logic [elns_pkg::CSR_INDEX_BITS-1:0] index;
   logic [elns_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/elns_queue.sv */
// ----------------------------------------------------------------------------
// elns_queue
// Small FIFO of result bundles between the front end and the back end.
// ----------------------------------------------------------------------------
`include "eol_normalizing_line_splitter_assert.svh"

module elns_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  elns_pkg::bundle_type push_data,
   output logic                 full,
   input  logic                 pop,
   output elns_pkg::bundle_type head,
   output logic                 empty
);

   elns_pkg::bundle_type entry_ff [elns_pkg::QUEUE_DEPTH];
   logic [elns_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [elns_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [elns_pkg::QUEUE_COUNT_BITS-1:0] count_ff, count_in;

   assign full  = (count_ff == elns_pkg::QUEUE_FULL);
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ELNS_ASSERT_IMPLY(a_no_push_when_full, clock, reset, full, !push)
   `ELNS_ASSERT_NEXT(a_fill_grows, clock, reset, push && !pop,
                     count_ff == $past(count_ff) + 1'b1)

endmodule

/* rtl/elns_front.sv */
// ----------------------------------------------------------------------------
// elns_front
// Accepts request bytes, tracks held line-ending halves and form feeds,
// and builds the bundle of results that each request causes.
// ----------------------------------------------------------------------------
`include "eol_normalizing_line_splitter_assert.svh"

module elns_front (
   input  logic                   clock,
   input  logic                   reset,
   elns_req_if.sink               req,
   input  logic [2:0]             eol_mode,
   input  logic                   fold_case,
   input  logic                   queue_full,
   output elns_pkg::queue_ctl_type ctl,
   output elns_pkg::bundle_type   bundle
);

   typedef struct packed {
      logic [1:0]                               pend;
      logic                                     hff;
      logic                                     open;
      logic [elns_pkg::LINE_COUNT_BITS-1:0]     cnt;
      logic [1:0]                               n;
      elns_pkg::result_type [elns_pkg::MAX_RESULTS-1:0] slot;
   } work_type;

   logic [1:0]                           pend_ff, pend_in;
   logic                                 hff_ff, hff_in;
   logic                                 open_ff, open_in;
   logic [elns_pkg::LINE_COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                                 accept;
   logic [2:0]                           mode;
   work_type                             w;

   function automatic work_type emit(work_type w_i, logic [7:0] b, logic has,
                                     logic eol, logic comp, logic fold);
      work_type   r;
      logic [7:0] f;
      r = w_i;
      f = b;
      if (r.n != 2'd3) begin
         if (!r.open) begin
            r.cnt  = r.cnt + elns_pkg::LINE_COUNT_ONE;
            r.open = 1'b1;
         end
         if (fold && b >= elns_pkg::CH_UPPER_A && b <= elns_pkg::CH_UPPER_Z) begin
            f = b + elns_pkg::FOLD_OFFSET;
         end
         r.slot[r.n].out_byte      = b;
         r.slot[r.n].folded_byte   = f;
         r.slot[r.n].has_byte      = has;
         r.slot[r.n].end_of_line   = eol;
         r.slot[r.n].line_complete = comp;
         r.slot[r.n].line_number   = 32'(r.cnt);
         r.n = r.n + 2'd1;
         if (eol) begin
            r.open = 1'b0;
         end
      end
      return r;
   endfunction

   // A held form feed stands in for the ending it precedes.
   function automatic work_type emit_ending(work_type w_i, logic fold);
      work_type r;
      r = w_i;
      if (r.hff) begin
         r.hff = 1'b0;
         r = emit(r, elns_pkg::CH_FF, 1'b1, 1'b1, 1'b1, fold);
      end else begin
         r = emit(r, elns_pkg::CH_LF, 1'b1, 1'b1, 1'b1, fold);
      end
      return r;
   endfunction

   function automatic work_type flush_ff(work_type w_i, logic fold);
      work_type r;
      r = w_i;
      if (r.hff) begin
         r.hff = 1'b0;
         r = emit(r, elns_pkg::CH_FF, 1'b1, 1'b0, 1'b0, fold);
      end
      return r;
   endfunction

   function automatic logic single_ok(logic [2:0] m, logic [7:0] c);
      return (m == elns_pkg::MODE_ANY) ||
             (m == elns_pkg::MODE_CR && c == elns_pkg::CH_CR) ||
             (m == elns_pkg::MODE_LF && c == elns_pkg::CH_LF);
   endfunction

   function automatic logic pair_start(logic [2:0] m, logic [7:0] c);
      return (m == elns_pkg::MODE_ANY) ||
             (m == elns_pkg::MODE_CRLF && c == elns_pkg::CH_CR) ||
             (m == elns_pkg::MODE_LFCR && c == elns_pkg::CH_LF);
   endfunction

   // A lone half that does not end a line under this mode is a plain byte.
   function automatic work_type settle_half(work_type w_i, logic [2:0] m,
                                            logic [7:0] p, logic fold);
      work_type r;
      r = w_i;
      if (single_ok(m, p)) begin
         r = emit_ending(r, fold);
      end else begin
         r = flush_ff(r, fold);
         r = emit(r, p, 1'b1, 1'b0, 1'b0, fold);
      end
      return r;
   endfunction

   function automatic work_type take_fresh(work_type w_i, logic [2:0] m,
                                           logic [7:0] b, logic fold);
      work_type r;
      r = w_i;
      if (b == elns_pkg::CH_CR || b == elns_pkg::CH_LF) begin
         if (pair_start(m, b)) begin
            r.pend = (b == elns_pkg::CH_CR) ? elns_pkg::PEND_CR : elns_pkg::PEND_LF;
         end else begin
            r = settle_half(r, m, b, fold);
         end
      end else if (b == elns_pkg::CH_FF) begin
         r = flush_ff(r, fold);
         r.hff = 1'b1;
      end else begin
         r = flush_ff(r, fold);
         r = emit(r, b, 1'b1, 1'b0, 1'b0, fold);
      end
      return r;
   endfunction

   assign accept    = req.valid && req.ready;
   assign req.ready = !queue_full;
   assign mode      = (eol_mode > elns_pkg::MODE_ANY) ? elns_pkg::MODE_ANY : eol_mode;

   always_comb begin
      logic [7:0] p;
      logic [7:0] partner;
      logic       swallowed;
      w         = '0;
      w.pend    = pend_ff;
      w.hff     = hff_ff;
      w.open    = open_ff;
      w.cnt     = cnt_ff;
      p         = (pend_ff == elns_pkg::PEND_CR) ? elns_pkg::CH_CR : elns_pkg::CH_LF;
      partner   = (pend_ff == elns_pkg::PEND_CR) ? elns_pkg::CH_LF : elns_pkg::CH_CR;
      swallowed = 1'b0;
      if (req.end_of_input) begin
         if (pend_ff == elns_pkg::PEND_CR || pend_ff == elns_pkg::PEND_LF) begin
            w.pend = elns_pkg::PEND_NONE;
            w = settle_half(w, mode, p, fold_case);
         end
         w = flush_ff(w, fold_case);
         // An open line is closed by its last flushed byte, or by an empty result.
         if (w.open) begin
            if (w.n != 2'd0) begin
               w.slot[w.n - 2'd1].end_of_line   = 1'b1;
               w.slot[w.n - 2'd1].line_complete = 1'b0;
            end else begin
               w = emit(w, elns_pkg::CH_NUL, 1'b0, 1'b1, 1'b0, fold_case);
            end
         end
      end else begin
         if (pend_ff == elns_pkg::PEND_CR || pend_ff == elns_pkg::PEND_LF) begin
            w.pend = elns_pkg::PEND_NONE;
            if (req.in_byte == partner && pair_start(mode, p)) begin
               w = emit_ending(w, fold_case);
               swallowed = 1'b1;
            end else begin
               w = settle_half(w, mode, p, fold_case);
            end
         end
         if (!swallowed) begin
            w = take_fresh(w, mode, req.in_byte, fold_case);
         end
      end
   end

   always_comb begin
      if (req.end_of_input) begin
         pend_in = elns_pkg::PEND_NONE;
         hff_in  = 1'b0;
         open_in = 1'b0;
         cnt_in  = '0;
      end else begin
         pend_in = w.pend;
         hff_in  = w.hff;
         open_in = w.open;
         cnt_in  = w.cnt;
      end
   end

   assign bundle.count = w.n;
   assign bundle.slot  = w.slot;
   assign ctl.push     = accept && (w.n != 2'd0);
   assign ctl.full     = queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= elns_pkg::PEND_NONE;
         hff_ff  <= 1'b0;
         open_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (accept) begin
         pend_ff <= pend_in;
         hff_ff  <= hff_in;
         open_ff <= open_in;
         cnt_ff  <= cnt_in;
      end
   end

   `ELNS_ASSERT_NEXT(a_restart_after_end, clock, reset, accept && req.end_of_input,
                     pend_ff == elns_pkg::PEND_NONE && !hff_ff && !open_ff && cnt_ff == '0)

endmodule

/* rtl/elns_back.sv */
// ----------------------------------------------------------------------------
// elns_back
// Walks through the results of the head bundle and presents them one at a
// time in the response register.
// ----------------------------------------------------------------------------
`include "eol_normalizing_line_splitter_assert.svh"

module elns_back (
   input  logic                 clock,
   input  logic                 reset,
   input  elns_pkg::bundle_type head,
   input  logic                 empty,
   output logic                 pop,
   elns_rsp_if.source           rsp
);

   logic                 valid_ff, valid_in;
   elns_pkg::result_type data_ff;
   logic [1:0]           idx_ff, idx_in;
   logic                 load;
   logic                 last;

   assign load = !empty && (!valid_ff || rsp.ready);
   assign last = (idx_ff == head.count - 2'd1);
   assign pop  = load && last;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= head.slot[idx_ff];
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.out_byte      = data_ff.out_byte;
   assign rsp.folded_byte   = data_ff.folded_byte;
   assign rsp.has_byte      = data_ff.has_byte;
   assign rsp.end_of_line   = data_ff.end_of_line;
   assign rsp.line_complete = data_ff.line_complete;
   assign rsp.line_number   = data_ff.line_number;

   `ELNS_ASSERT_IMPLY(a_index_in_bundle, clock, reset, !empty, idx_ff < head.count)

endmodule

/* rtl/eol_normalizing_line_splitter.sv */
// ----------------------------------------------------------------------------
// eol_normalizing_line_splitter
// Splits a byte stream into lines and gives every accepted ending as LF, or as FF where a held form feed precedes it.
// ----------------------------------------------------------------------------
// A request carries one byte, or an end-of-input marker that flushes held
// bytes, closes a partial line and restarts numbering at 1. Each request
// gives zero to three responses. Requests are taken one per cycle while the
// bundle queue is not full; the response register drains one result per
// cycle while the receiver is ready, and a four-entry bundle queue between
// the front end and the output absorbs the bursts of requests that cause two
// or three results. A result passes through the queue and the response
// register before it reaches the response channel. Register writes are taken
// at any time, one per cycle, and should be made while no request is in flight.

module eol_normalizing_line_splitter (
   input  logic        clock,
   input  logic        reset,
   elns_req_if.sink    req_bus,
   elns_rsp_if.source  rsp_bus,
   elns_csr_if.sink    csr_bus
);

   logic [2:0]              eol_mode_ff, eol_mode_in;
   logic                    fold_case_ff, fold_case_in;
   logic                    csr_write;
   elns_pkg::queue_ctl_type ctl;
   elns_pkg::bundle_type    push_data;
   elns_pkg::bundle_type    head;
   logic                    full;
   logic                    empty;
   logic                    pop;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_comb begin
      eol_mode_in  = eol_mode_ff;
      fold_case_in = fold_case_ff;
      if (csr_write && csr_bus.index == elns_pkg::CSR_EOL_MODE) begin
         eol_mode_in = csr_bus.data[2:0];
      end
      if (csr_write && csr_bus.index == elns_pkg::CSR_FOLD_CASE) begin
         fold_case_in = csr_bus.data[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eol_mode_ff  <= elns_pkg::MODE_ANY;
         fold_case_ff <= 1'b0;
      end else begin
         eol_mode_ff  <= eol_mode_in;
         fold_case_ff <= fold_case_in;
      end
   end

   elns_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .eol_mode   (eol_mode_ff),
      .fold_case  (fold_case_ff),
      .queue_full (full),
      .ctl        (ctl),
      .bundle     (push_data)
   );

   elns_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ctl.push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head      (head),
      .empty     (empty)
   );

   elns_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp_bus)
   );

endmodule
